// ===== sv/ioirc_pkg.sv =====
// Shared types and constants for the I/O interrupt redirection controller.
// No dependencies; imported by the top level, the controller and the datapath.
package ioirc_pkg;

	localparam int PIN_COUNT    = 48;
	localparam int VERSION_CODE = 33;

	// pin index width; the table lives as two 32-bit words per pin
	localparam int IDX_W     = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
	localparam int RAM_DEPTH = 2 * PIN_COUNT;
	localparam int RAM_AW    = $clog2(RAM_DEPTH);

	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_PIN   = 2'd2;

	localparam logic [7:0] REG_SELECT = 8'h00;
	localparam logic [7:0] REG_WINDOW = 8'h10;
	localparam logic [7:0] REG_EOI    = 8'h40;

	localparam logic [31:0] SEL_VERSION = 32'h1;
	localparam logic [31:0] WIN_BASE    = 32'h10;

	// reset entry is 0x10000: mask set in the low word, high word zero
	localparam logic [31:0] RESET_LO = 32'h0001_0000;
	localparam logic [31:0] RESET_HI = 32'h0000_0000;

	localparam logic [31:0] VERSION_WORD =
		{8'h00, 8'(PIN_COUNT - 1), 8'h00, 8'(VERSION_CODE)};

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  bus_address;
		logic [31:0] write_data;
		logic [5:0]  pin_number;
		logic        pin_level;
	} item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        deliver_valid;
		logic [15:0] deliver_dest;
		logic [2:0]  deliver_mode;
		logic [7:0]  deliver_vector;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic load_item;
		logic rd_sel;
		logic rd_ver;
		logic rd_ram;
		logic cap_read;
		logic wr_sel;
		logic wr_ram;
		logic load_match;
		logic eoi_clear;
		logic pin_update;
		logic pick_commit;
		logic cap_low;
		logic cap_high;
		logic load_out;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic rd_sel;
		logic rd_ver;
		logic rd_ram;
		logic wr_sel;
		logic wr_ram;
		logic eoi;
		logic pin_act;
		logic eoi_hit;
		logic pick_any;
		logic out_free;
	} ctl_sts_t;

endpackage

// ===== sv/io_interrupt_redirection_controller.sv =====
// I/O interrupt redirection controller, top level.
// Depends on ioirc_pkg, ioirc_ctrl, ioirc_datapath (which holds ioirc_ram).
//
// One transaction in, one result out, one item at a time. After the accept
// the item is decoded; select accesses, window writes and ignored items
// (masked and out-of-range pins included) then go to the output step. A
// table read through the window first waits for the registered RAM read.
// An EOI registers the vector match of its lookup; one that ends nothing
// finishes there, one that ends an in-service entry goes on to the pick,
// like a pin event. A pick that finds a pin reads the entry as two 32-bit
// words through the single read port of the table RAM. A finished result
// sits in an output register, so the next item is taken while it waits;
// the block stalls only when a second result is ready before the first one
// was taken. No clearing pass after reset.
module io_interrupt_redirection_controller (
	input  logic               clk,
	input  logic               arst_n,
	input  ioirc_pkg::item_t   item,
	input  logic               item_valid,
	output logic               item_ready,
	output ioirc_pkg::result_t result,
	output logic               result_valid,
	input  logic               result_ready
);
	import ioirc_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	ioirc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ioirc_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.cmd         (cmd),
		.sts         (sts),
		.result      (result),
		.result_valid(result_valid),
		.result_ready(result_ready)
	);

endmodule

// ===== sv/ioirc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ioirc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/ioirc_datapath.sv =====
// Datapath: item register, select/pending/in-service state, table storage
// (RAM plus per-pin shadow of vector, trigger and mask), result registers.
// Depends on ioirc_pkg and ioirc_ram.
module ioirc_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  ioirc_pkg::item_t   item,
	input  ioirc_pkg::ctl_cmd_t cmd,
	output ioirc_pkg::ctl_sts_t sts,
	output ioirc_pkg::result_t result,
	output logic               result_valid,
	input  logic               result_ready
);
	import ioirc_pkg::*;

	item_t              item_q;
	result_t            res_q;
	logic [31:0]        select_q;
	logic [PIN_COUNT-1:0] pending_q;
	logic [PIN_COUNT-1:0] isr_q;
	logic [PIN_COUNT-1:0] match_q;
	logic [RAM_DEPTH-1:0] valid_q;
	logic [7:0]         vec_q [PIN_COUNT];
	logic [PIN_COUNT-1:0] level_q;
	logic [PIN_COUNT-1:0] mask_q;
	logic [IDX_W-1:0]   pick_idx_q;
	logic               rd_valid_q;
	logic [31:0]        rd_dflt_q;

	logic [31:0]        sel_off;
	logic               win_in_range;
	logic               sel_version;
	logic [IDX_W-1:0]   widx;
	logic [IDX_W-1:0]   pidx;
	logic               pin_ok;
	logic               eoi_any;
	logic [IDX_W-1:0]   eoi_idx;
	logic               pick_any;
	logic [IDX_W-1:0]   pick_idx;
	logic [PIN_COUNT-1:0] ready_pins;

	logic               ram_re;
	logic [RAM_AW-1:0]  ram_raddr;
	logic [31:0]        ram_rdata;
	logic [31:0]        rd_word;

	// window addressing, 32-bit wraparound
	assign sel_off      = select_q - WIN_BASE;
	assign win_in_range = sel_off[31:1] < 31'(PIN_COUNT);
	assign sel_version  = select_q == SEL_VERSION;
	assign widx         = sel_off[IDX_W:1];

	assign pin_ok = {1'b0, item_q.pin_number} < 7'(PIN_COUNT);
	assign pidx   = item_q.pin_number[IDX_W-1:0];

	// lowest entry whose vector matches the EOI data
	always_comb begin
		eoi_any = 1'b0;
		eoi_idx = '0;
		for (int i = PIN_COUNT - 1; i >= 0; i--) begin
			if (match_q[i]) begin
				eoi_any = 1'b1;
				eoi_idx = IDX_W'(i);
			end
		end
	end

	// highest pending pin not in service
	assign ready_pins = pending_q & ~isr_q;
	always_comb begin
		pick_any = 1'b0;
		pick_idx = '0;
		for (int i = 0; i < PIN_COUNT; i++) begin
			if (ready_pins[i]) begin
				pick_any = 1'b1;
				pick_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		sts = '0;
		unique case (item_q.command)
			CMD_READ: begin
				sts.rd_sel = item_q.bus_address == REG_SELECT;
				sts.rd_ver = (item_q.bus_address == REG_WINDOW) && sel_version;
				sts.rd_ram = (item_q.bus_address == REG_WINDOW) && !sel_version &&
					win_in_range;
			end
			CMD_WRITE: begin
				sts.wr_sel = item_q.bus_address == REG_SELECT;
				sts.wr_ram = (item_q.bus_address == REG_WINDOW) && !sel_version &&
					win_in_range;
				sts.eoi    = item_q.bus_address == REG_EOI;
			end
			CMD_PIN: begin
				sts.pin_act = pin_ok && !mask_q[pidx];
			end
			default: begin
			end
		endcase
		sts.eoi_hit  = eoi_any && isr_q[eoi_idx];
		sts.pick_any = pick_any;
		sts.out_free = !result_valid || result_ready;
	end

	// single read port shared by window reads and the two delivery reads
	always_comb begin
		ram_re    = cmd.rd_ram || cmd.pick_commit || cmd.cap_low;
		ram_raddr = sel_off[RAM_AW-1:0];
		priority if (cmd.pick_commit) begin
			ram_raddr = RAM_AW'({pick_idx, 1'b0});
		end else if (cmd.cap_low) begin
			ram_raddr = RAM_AW'({pick_idx_q, 1'b1});
		end
	end

	ioirc_ram #(
		.WIDTH(32),
		.DEPTH(RAM_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (cmd.wr_ram),
		.waddr(sel_off[RAM_AW-1:0]),
		.wdata(item_q.write_data),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// unwritten words read as their reset value
	assign rd_word = rd_valid_q ? ram_rdata : rd_dflt_q;

	always_ff @(posedge clk) begin
		if (ram_re) begin
			rd_dflt_q <= ram_raddr[0] ? RESET_HI : RESET_LO;
		end
		if (cmd.load_item) begin
			item_q <= item;
		end
		if (cmd.load_match) begin
			for (int i = 0; i < PIN_COUNT; i++) begin
				match_q[i] <= (item_q.write_data[31:8] == 24'h0) &&
					(vec_q[i] == item_q.write_data[7:0]);
			end
		end
		if (cmd.pick_commit) begin
			pick_idx_q <= pick_idx;
		end
		if (cmd.load_item) begin
			res_q <= '0;
		end
		if (cmd.rd_sel) begin
			res_q.read_data <= select_q;
		end
		if (cmd.rd_ver) begin
			res_q.read_data <= VERSION_WORD;
		end
		if (cmd.cap_read) begin
			res_q.read_data <= rd_word;
		end
		if (cmd.cap_low) begin
			res_q.deliver_valid  <= 1'b1;
			res_q.deliver_vector <= rd_word[7:0];
			res_q.deliver_mode   <= rd_word[10:8];
		end
		if (cmd.cap_high) begin
			res_q.deliver_dest <= rd_word[31:16];
		end
		if (cmd.load_out) begin
			result <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_q     <= '0;
			pending_q    <= '0;
			isr_q        <= '0;
			valid_q      <= '0;
			level_q      <= '0;
			mask_q       <= '1;
			rd_valid_q   <= 1'b0;
			result_valid <= 1'b0;
			for (int i = 0; i < PIN_COUNT; i++) begin
				vec_q[i] <= '0;
			end
		end else begin
			if (ram_re) begin
				rd_valid_q <= valid_q[ram_raddr];
			end
			if (cmd.wr_sel) begin
				select_q <= item_q.write_data;
			end
			if (cmd.wr_ram) begin
				valid_q[sel_off[RAM_AW-1:0]] <= 1'b1;
				if (!sel_off[0]) begin
					vec_q[widx]   <= item_q.write_data[7:0];
					level_q[widx] <= item_q.write_data[15];
					mask_q[widx]  <= item_q.write_data[16];
				end
			end
			if (cmd.pin_update) begin
				if (level_q[pidx]) begin
					pending_q[pidx] <= item_q.pin_level;
				end else if (item_q.pin_level) begin
					pending_q[pidx] <= 1'b1;
				end
			end
			if (cmd.eoi_clear) begin
				isr_q[eoi_idx] <= 1'b0;
			end
			if (cmd.pick_commit) begin
				pending_q[pick_idx] <= 1'b0;
				if (level_q[pick_idx]) begin
					isr_q[pick_idx] <= 1'b1;
				end
			end
			if (cmd.load_out) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/ioirc_ctrl.sv =====
// Controller state machine: sequences decode, table reads, EOI lookup and
// the delivery pick. Depends on ioirc_pkg.
module ioirc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  ioirc_pkg::ctl_sts_t sts,
	output ioirc_pkg::ctl_cmd_t cmd
);
	import ioirc_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_EXEC   = 8'b0000_0010,
		S_RDWAIT = 8'b0000_0100,
		S_EOI    = 8'b0000_1000,
		S_PICK   = 8'b0001_0000,
		S_PLO    = 8'b0010_0000,
		S_PHI    = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	assign item_ready = state_q == S_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_EXEC;
				end
			end
			S_EXEC: begin
				priority if (sts.rd_ram) begin
					cmd.rd_ram = 1'b1;
					state_d    = S_RDWAIT;
				end else if (sts.eoi) begin
					cmd.load_match = 1'b1;
					state_d        = S_EOI;
				end else if (sts.pin_act) begin
					cmd.pin_update = 1'b1;
					state_d        = S_PICK;
				end else begin
					cmd.rd_sel = sts.rd_sel;
					cmd.rd_ver = sts.rd_ver;
					cmd.wr_sel = sts.wr_sel;
					cmd.wr_ram = sts.wr_ram;
					state_d    = S_DONE;
				end
			end
			S_RDWAIT: begin
				cmd.cap_read = 1'b1;
				state_d      = S_DONE;
			end
			S_EOI: begin
				if (sts.eoi_hit) begin
					cmd.eoi_clear = 1'b1;
					state_d       = S_PICK;
				end else begin
					state_d = S_DONE;
				end
			end
			S_PICK: begin
				if (sts.pick_any) begin
					cmd.pick_commit = 1'b1;
					state_d         = S_PLO;
				end else begin
					state_d = S_DONE;
				end
			end
			S_PLO: begin
				cmd.cap_low = 1'b1;
				state_d     = S_PHI;
			end
			S_PHI: begin
				cmd.cap_high = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== tb/sv/io_interrupt_redirection_controller_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for io_interrupt_redirection_controller.
// Depends on ioirc_pkg and the RTL; keeps its own copy of the table and masks.

module io_interrupt_redirection_controller_tb;
	import ioirc_pkg::*;

	localparam logic [1:0] CMD_NONE      = 2'd3;
	localparam int         TRIG_BIT      = 15;
	localparam int         MASK_BIT      = 16;
	localparam logic [63:0] ENTRY_RESET  = 64'h0000_0000_0001_0000;
	localparam int         RANDOM_ITEMS  = 1300;
	localparam int         CALM_TAIL     = 150;
	localparam int         WATCHDOG_MAX  = 2000;
	localparam int         SETTLE_CYCLES = 16;

	// Shadow of the controller: redirection table, pending/in-service masks, select.
	class redirect_scoreboard;
		logic [63:0]          rte [PIN_COUNT];
		logic [PIN_COUNT-1:0] pending;
		logic [PIN_COUNT-1:0] in_service;
		logic [31:0]          sel_reg;
		result_t              awaited_results [$];
		int                   failures;

		function new();
			foreach (rte[i]) rte[i] = ENTRY_RESET;
			pending    = '0;
			in_service = '0;
			sel_reg    = '0;
			failures   = 0;
		endfunction

		function logic [31:0] version_word();
			return ((32'(PIN_COUNT - 1) & 32'hff) << 16) | (32'(VERSION_CODE) & 32'hff);
		endfunction

		// highest pending pin not in service wins; level pins go in service
		function void deliver_highest(inout result_t r);
			logic [PIN_COUNT-1:0] eligible;
			eligible = pending & ~in_service;
			for (int i = PIN_COUNT - 1; i >= 0; i--) begin
				if (eligible[i]) begin
					if (rte[i][TRIG_BIT]) in_service[i] = 1'b1;
					pending[i]       = 1'b0;
					r.deliver_valid  = 1'b1;
					r.deliver_dest   = rte[i][63:48];
					r.deliver_mode   = rte[i][10:8];
					r.deliver_vector = rte[i][7:0];
					return;
				end
			end
		endfunction

		function void predict_outcome(item_t it);
			result_t     r;
			logic [31:0] idx;
			logic [63:0] e;
			int          hit;
			r   = '0;
			idx = (sel_reg - WIN_BASE) >> 1;
			hit = -1;
			case (it.command)
			CMD_READ: begin
				if (it.bus_address == REG_SELECT) begin
					r.read_data = sel_reg;
				end else if (it.bus_address == REG_WINDOW) begin
					if (sel_reg == SEL_VERSION) begin
						r.read_data = version_word();
					end else if (idx < PIN_COUNT) begin
						r.read_data = sel_reg[0] ? rte[idx][63:32] : rte[idx][31:0];
					end
				end
			end
			CMD_WRITE: begin
				if (it.bus_address == REG_SELECT) begin
					sel_reg = it.write_data;
				end else if (it.bus_address == REG_WINDOW) begin
					if (sel_reg != SEL_VERSION && idx < PIN_COUNT) begin
						if (sel_reg[0]) rte[idx][63:32] = it.write_data;
						else rte[idx][31:0] = it.write_data;
					end
				end else if (it.bus_address == REG_EOI) begin
					// lowest entry with that vector; data above 0xff never matches
					for (int i = 0; i < PIN_COUNT; i++) begin
						if (hit < 0 && 32'(rte[i][7:0]) == it.write_data) hit = i;
					end
					if (hit >= 0 && in_service[hit]) begin
						in_service[hit] = 1'b0;
						deliver_highest(r);
					end
				end
			end
			CMD_PIN: begin
				if (it.pin_number < PIN_COUNT) begin
					e = rte[it.pin_number];
					if (!e[MASK_BIT]) begin
						if (e[TRIG_BIT]) pending[it.pin_number] = it.pin_level;
						else if (it.pin_level) pending[it.pin_number] = 1'b1;
						deliver_highest(r);
					end
				end
			end
			default: ;
			endcase
			awaited_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
				failures++;
			end
		endfunction

		function void check_outcome(result_t got);
			result_t want;
			if (awaited_results.size() == 0) begin
				$error("result with nothing outstanding: %p", got);
				failures++;
				return;
			end
			want = awaited_results.pop_front();
			compare_field("read_data", want.read_data, got.read_data);
			compare_field("deliver_valid", 32'(want.deliver_valid), 32'(got.deliver_valid));
			compare_field("deliver_dest", 32'(want.deliver_dest), 32'(got.deliver_dest));
			compare_field("deliver_mode", 32'(want.deliver_mode), 32'(got.deliver_mode));
			compare_field("deliver_vector", 32'(want.deliver_vector), 32'(got.deliver_vector));
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	item_t   item;
	logic    item_valid;
	logic    item_ready;
	result_t result;
	logic    result_valid;
	logic    result_ready;
	logic    calm;
	int      items_sent;

	redirect_scoreboard sb = new();

	io_interrupt_redirection_controller dut (
		.clk,
		.arst_n,
		.item,
		.item_valid,
		.item_ready,
		.result,
		.result_valid,
		.result_ready
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic item_t random_item();
		item_t it;
		it.command = 2'($urandom_range(0, 3));
		case ($urandom_range(0, 3))
		0: it.bus_address = REG_SELECT;
		1: it.bus_address = REG_WINDOW;
		2: it.bus_address = REG_EOI;
		default: it.bus_address = 8'($urandom_range(0, 255));
		endcase
		it.write_data = $urandom;
		it.pin_number = 6'($urandom_range(0, 63));
		it.pin_level  = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic logic [63:0] random_entry();
		logic [63:0] e;
		e = {$urandom, $urandom};
		// narrow vector pool so EOI lookups hit shared vectors
		if ($urandom_range(0, 3) != 0) e[7:0] = 8'hE0 | 8'($urandom_range(0, 7));
		e[MASK_BIT] = ($urandom_range(0, 3) == 0);
		return e;
	endfunction

	task automatic send_item(input item_t it);
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		sb.predict_outcome(it);
		items_sent++;
		if (!calm && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic bus_write(input logic [7:0] addr, input logic [31:0] data);
		item_t it;
		it             = random_item();
		it.command     = CMD_WRITE;
		it.bus_address = addr;
		it.write_data  = data;
		send_item(it);
	endtask

	task automatic bus_read(input logic [7:0] addr);
		item_t it;
		it             = random_item();
		it.command     = CMD_READ;
		it.bus_address = addr;
		send_item(it);
	endtask

	task automatic pin_change(input logic [5:0] pin, input logic lvl);
		item_t it;
		it            = random_item();
		it.command    = CMD_PIN;
		it.pin_number = pin;
		it.pin_level  = lvl;
		send_item(it);
	endtask

	task automatic set_entry(input int pin, input logic [63:0] e);
		bus_write(REG_SELECT, WIN_BASE + 2 * pin);
		bus_write(REG_WINDOW, e[31:0]);
		bus_write(REG_SELECT, WIN_BASE + 2 * pin + 1);
		bus_write(REG_WINDOW, e[63:32]);
	endtask

	task automatic wait_for_drain();
		item_valid <= 1'b0;
		while (sb.awaited_results.size() != 0) @(posedge clk);
	endtask

	// result side: random backpressure bursts, none once calm
	initial begin
		int hold;
		hold         = 0;
		result_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && result_ready) sb.check_outcome(result);
			if (hold > 0) begin
				hold--;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				result_ready <= 1'b0;
				hold = $urandom_range(0, 13);
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// no transaction on either side for too long means the block hung
	initial begin
		int idle;
		idle = 0;
		while (idle < WATCHDOG_MAX) begin
			@(posedge clk);
			if ((item_valid && item_ready) || (result_valid && result_ready)) idle = 0;
			else idle++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		item_t it;
		logic [63:0] e;
		int start;
		int pin;
		int busy [$];
		bit drained_mid;
		arst_n      = 1'b0;
		item        = '0;
		item_valid  = 1'b0;
		calm        = 1'b0;
		items_sent  = 0;
		drained_mid = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		bus_read(REG_SELECT);
		bus_read(REG_WINDOW);                   // select 0 wraps far out of the table
		bus_write(REG_SELECT, SEL_VERSION);
		bus_write(REG_WINDOW, 32'hFFFF_FFFF);   // version word is read only
		bus_read(REG_WINDOW);
		pin_change(6'd0, 1'b1);                 // still masked from reset
		set_entry(0, 64'h0000_0000_0000_8000);  // level, vector 0x00, mode 0
		set_entry(PIN_COUNT - 1, 64'hFFFF_0000_0000_07FF); // edge, vector 0xff, mode 7
		pin_change(6'(PIN_COUNT - 1), 1'b0);    // edge deassert, pick finds nothing
		pin_change(6'd0, 1'b1);
		pin_change(6'(PIN_COUNT - 1), 1'b1);
		pin_change(6'd0, 1'b1);                 // held back while in service
		bus_write(REG_EOI, 32'h0000_0100);      // above any vector
		bus_write(REG_EOI, 32'h0000_0000);      // ends pin 0, redelivers it
		bus_read(REG_EOI);
		pin_change(6'd63, 1'b1);
		bus_write(8'hFF, 32'hFFFF_FFFF);
		it         = random_item();
		it.command = CMD_NONE;
		send_item(it);
		bus_write(REG_SELECT, WIN_BASE + 2 * PIN_COUNT);
		bus_write(REG_WINDOW, 32'hFFFF_FFFF);
		bus_read(REG_WINDOW);
		wait_for_drain();

		start = items_sent;
		for (int i = 0; i < PIN_COUNT; i++) set_entry(i, random_entry());

		while (items_sent - start < RANDOM_ITEMS) begin
			if (items_sent - start >= RANDOM_ITEMS - CALM_TAIL) calm = 1'b1;
			if (!drained_mid && items_sent - start >= RANDOM_ITEMS / 2) begin
				wait_for_drain();
				drained_mid = 1'b1;
			end
			pin = $urandom_range(0, PIN_COUNT - 1);
			case ($urandom_range(0, 9))
			0, 1: begin
				e = random_entry();
				bus_write(REG_SELECT, WIN_BASE + 2 * pin);
				bus_write(REG_WINDOW, e[31:0]);
				if ($urandom_range(0, 1)) begin
					bus_write(REG_SELECT, WIN_BASE + 2 * pin + 1);
					bus_write(REG_WINDOW, e[63:32]);
				end
			end
			2: begin
				if ($urandom_range(0, 3) == 0) bus_write(REG_SELECT, $urandom);
				else bus_write(REG_SELECT, WIN_BASE + 2 * pin + $urandom_range(0, 1));
				bus_read(REG_WINDOW);
				if ($urandom_range(0, 3) == 0) bus_read(REG_SELECT);
			end
			3, 4, 5, 6: begin
				pin_change(6'(pin), 1'($urandom_range(0, 1)));
			end
			7: begin
				busy.delete();
				for (int i = 0; i < PIN_COUNT; i++) begin
					if (sb.in_service[i]) busy.push_back(i);
				end
				if (busy.size() != 0)
					bus_write(REG_EOI,
						32'(sb.rte[busy[$urandom_range(0, busy.size() - 1)]][7:0]));
				else
					bus_write(REG_EOI, $urandom_range(0, 255));
			end
			default: begin
				send_item(random_item());
			end
			endcase
		end

		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== io_interrupt_redirection_controller.f =====
sv/ioirc_pkg.sv
sv/ioirc_ram.sv
sv/ioirc_datapath.sv
sv/ioirc_ctrl.sv
sv/io_interrupt_redirection_controller.sv
tb/sv/io_interrupt_redirection_controller_tb.sv
